/* hw/rtl/bez_pkg.sv */
// bez_pkg: shared types and constants for the bezier point and derivative evaluator
// no dependencies
`default_nettype none
package bez_pkg;
  localparam int CW = 32;
  localparam int TW = 17;
  localparam int WW = 64;

  typedef enum logic {ACT_WRITE = 1'b0, ACT_EVAL = 1'b1} act_t;
  typedef enum logic {ST_OK = 1'b0, ST_BAD_INDEX = 1'b1} stat_t;

  typedef struct packed {
    logic              action;
    logic [2:0]        point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [16:0]       t_fraction;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
    logic              status;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_LOAD, S_LOADW, S_DIFF, S_LERPM, S_LERPA, S_NEXT, S_DONE
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [WW-1:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

/* hw/rtl/bezier_point_and_derivatives_top.sv */
// bezier_point_and_derivatives_top: command port, sequencer and shared lerp multiplier
// depends on bez_pkg and bez_ctrl_mem
//
// Usage: pulse start with in_word while busy is low. A write word stores one
// control point (or flags status when the index is not below the count); its
// result strobe follows the three S_LOAD states and S_DONE. An evaluate word
// computes, per coordinate, the curve point, first and second derivative by
// de Casteljau interpolation on one shared 64x17 multiplier, after loading
// the points from memory and, for a derivative, differencing them; each
// interpolation step passes through S_LERPM, S_LERPA and S_NEXT. One word is
// in flight at a time; the next word can be taken at the edge that ends the
// result cycle.
// The result appears for one cycle on out_word with out_valid; the receiver
// cannot stall it. cfg_data sets point_count while cfg_valid and cfg_ready.
// After reset the block clears all 3*MAX_POINTS entries of its coordinate
// memory, one entry a cycle, while busy is high; point_count resets to 4.
`default_nettype none
module bezier_point_and_derivatives_top import bez_pkg::*; #(
  parameter int MAX_POINTS = 6
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  output out_word_t      out_word,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [2:0] cfg_data
);
  localparam int DEPTH = 3 * MAX_POINTS;
  localparam int AW = $clog2(DEPTH + 1);
  localparam int PW = $clog2(MAX_POINTS + 1);

  state_t state_r, state_nxt;
  logic [2:0] cnt_r;
  logic [AW-1:0] clr_r;
  in_word_t cmd_r;
  logic [16:0] t_r;
  logic [1:0] crd_r, pass_r;
  logic [PW-1:0] ld_r, len_r, i_r, dcnt_r;
  logic signed [WW-1:0] buf_r [MAX_POINTS];
  logic signed [WW-1:0] prod_r;
  out_word_t res_r;
  logic ov_r;

  logic [2:0] eff;
  always_comb begin
    eff = cnt_r;
    if (eff == 3'd0) eff = 3'd1;
    if (32'(eff) > MAX_POINTS) eff = 3'(MAX_POINTS);
  end

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [CW-1:0] wdata, rdata;
  bez_ctrl_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic wr_ok;
  assign wr_ok = {1'b0, cmd_r.point_index} < {1'b0, eff};
  assign busy = state_r != S_IDLE;
  assign cfg_ready = state_r == S_IDLE;
  assign out_valid = ov_r;
  assign out_word = res_r;

  always_comb begin
    we = 1'b0; waddr = clr_r; wdata = '0;
    if (state_r == S_CLEAR) begin
      we = 1'b1;
    end else if (state_r == S_LOAD && cmd_r.action == ACT_WRITE && wr_ok) begin
      we = 1'b1;
      waddr = AW'(cmd_r.point_index * 3 + {1'b0, crd_r});
      wdata = crd_r == 2'd0 ? cmd_r.point_x : crd_r == 2'd1 ? cmd_r.point_y : cmd_r.point_z;
    end
    raddr = AW'(ld_r * 3 + crd_r);
  end

  logic [2:0] k;
  logic signed [WW-1:0] dif, lerp;
  always_comb begin
    k = (dcnt_r == '0) ? eff - 3'd1 : eff - 3'd2;
    dif = buf_r[i_r + PW'(1)] - buf_r[i_r];
    lerp = buf_r[i_r] + ((prod_r + 64'sd32768) >>> 16);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_LOAD;
      S_CLEAR: if (32'(clr_r) == DEPTH - 1) state_nxt = S_IDLE;
      S_LOAD:  if (cmd_r.action == ACT_WRITE) begin
                 if (crd_r == 2'd2) state_nxt = S_DONE;
               end else state_nxt = S_LOADW;
      S_LOADW: if (32'(ld_r) == 32'(eff)) state_nxt = (pass_r == 2'd0) ? S_NEXT : S_DIFF;
      S_DIFF:  if (32'(dcnt_r) + 1 == 32'(pass_r) && 32'(i_r) + 2 >= 32'(len_r))
                 state_nxt = S_NEXT;
      S_NEXT:  if (len_r > PW'(1)) state_nxt = S_LERPM;
               else if (pass_r != 2'd2 && 32'(eff) >= 32'(pass_r) + 2) state_nxt = S_LOAD;
               else if (crd_r != 2'd2) state_nxt = S_LOAD;
               else state_nxt = S_DONE;
      S_LERPM: state_nxt = S_LERPA;
      S_LERPA: state_nxt = S_NEXT;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd4; clr_r <= '0; ov_r <= 1'b0;
    end else begin
      ov_r <= state_r == S_DONE;
      if (cfg_valid && cfg_ready) cnt_r <= cfg_data;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
        end
        S_IDLE: begin
          if (start) begin
            cmd_r <= in_word; crd_r <= '0; pass_r <= '0; ld_r <= '0;
            t_r <= in_word.t_fraction > 17'h10000 ? 17'h10000 : in_word.t_fraction;
            res_r <= '0;
          end
        end
        S_LOAD: begin
          if (cmd_r.action == ACT_WRITE) begin
            crd_r <= crd_r + 2'd1;
            res_r.status <= wr_ok ? ST_OK : ST_BAD_INDEX;
          end else begin
            ld_r <= ld_r + PW'(1);
          end
        end
        S_LOADW: begin
          buf_r[ld_r - PW'(1)] <= WW'($signed(rdata));
          if (32'(ld_r) == 32'(eff)) begin
            i_r <= '0; dcnt_r <= '0; len_r <= PW'(eff);
          end else ld_r <= ld_r + PW'(1);
        end
        S_DIFF: begin
          buf_r[i_r] <= dif * $signed({1'b0, k});
          if (32'(i_r) + 2 >= 32'(len_r)) begin
            i_r <= '0; len_r <= len_r - PW'(1); dcnt_r <= dcnt_r + PW'(1);
          end else i_r <= i_r + PW'(1);
        end
        S_NEXT: begin
          if (len_r <= PW'(1)) begin
            unique case (pass_r)
              2'd0: begin
                if (crd_r == 2'd0) res_r.pos_x <= sat32(buf_r[0]);
                if (crd_r == 2'd1) res_r.pos_y <= sat32(buf_r[0]);
                if (crd_r == 2'd2) res_r.pos_z <= sat32(buf_r[0]);
              end
              2'd1: begin
                if (crd_r == 2'd0) res_r.vel_x <= sat32(buf_r[0]);
                if (crd_r == 2'd1) res_r.vel_y <= sat32(buf_r[0]);
                if (crd_r == 2'd2) res_r.vel_z <= sat32(buf_r[0]);
              end
              default: begin
                if (crd_r == 2'd0) res_r.acc_x <= sat32(buf_r[0]);
                if (crd_r == 2'd1) res_r.acc_y <= sat32(buf_r[0]);
                if (crd_r == 2'd2) res_r.acc_z <= sat32(buf_r[0]);
              end
            endcase
            ld_r <= '0;
            if (pass_r != 2'd2 && 32'(eff) >= 32'(pass_r) + 2) begin
              pass_r <= pass_r + 2'd1;
            end else if (crd_r != 2'd2) begin
              pass_r <= '0; crd_r <= crd_r + 2'd1;
            end
          end
        end
        S_LERPM: begin
          prod_r <= dif * $signed({1'b0, t_r});
        end
        S_LERPA: begin
          buf_r[i_r] <= lerp;
          if (32'(i_r) + 2 >= 32'(len_r)) begin
            i_r <= '0; len_r <= len_r - PW'(1);
          end else i_r <= i_r + PW'(1);
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/bez_ctrl_mem.sv */
// bez_ctrl_mem: control point store, one synchronous memory of coordinates
// depends on bez_pkg
`default_nettype none
module bez_ctrl_mem import bez_pkg::*; #(
  parameter int DEPTH = 18,
  parameter int AW = 5
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [CW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [CW-1:0] rdata
);
  logic [CW-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* hw/rtl/bez_checker.sv */
// bez_checker: port-level checks of the evaluator, bound to the top level
// depends on bez_pkg and bezier_point_and_derivatives_top
`default_nettype none
module bez_checker import bez_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      out_valid,
  input wire out_word_t out_word,
  input wire in_word_t  in_word
);
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted word did not raise busy");
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy during result");
  a_evok: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_word.action == ACT_EVAL |-> ##2 !out_valid)
    else $error("evaluation answered too soon");
endmodule

bind bezier_point_and_derivatives_top bez_checker u_bez_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_word(out_word), .in_word(in_word)
);
`default_nettype wire
